### src/lse_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the lsb stego embed sequencer
package lse_pkg;

  localparam int CHAR_BITS  = 7;
  localparam int SEQ_BITS   = 2 * CHAR_BITS;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int OFFSET_W   = 24;
  localparam int KEY_W      = 64;
  localparam int KEY_LEN_W  = 4;
  localparam int KEY_IDX_W  = 3;

  localparam logic [CHAR_BITS-1:0] EOT_CODE = 7'h04;

  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 2'd3;

  localparam logic [2:0] STEP_LAST = 3'd5;

  typedef struct packed {
    logic [CHAR_BITS-1:0] code;
    logic                 has_char;
    logic                 has_end;
    logic                 restart;
  } item_t;

  // repeating position steps 1,1,2,3,5,8
  function automatic logic [3:0] step_size(input logic [2:0] phase);
    logic [3:0] s;
    begin
      unique case (phase)
        3'd0:    s = 4'd1;
        3'd1:    s = 4'd1;
        3'd2:    s = 4'd2;
        3'd3:    s = 4'd3;
        3'd4:    s = 4'd5;
        3'd5:    s = 4'd8;
        default: s = 4'd1;
      endcase
      return s;
    end
  endfunction

endpackage

### src/lse_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for message words and write command words
interface lse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_present;
  logic       message_end;

  modport source (output valid, output char_code, output char_present,
                  output message_end, input ready);
  modport sink   (input valid, input char_code, input char_present,
                  input message_end, output ready);
endinterface

interface lse_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_position;
  logic [1:0]  channel;
  logic        bit_value;
  logic        out_of_range;
  logic        run_last;

  modport source (output valid, output pixel_position, output channel,
                  output bit_value, output out_of_range, output run_last,
                  input ready);
  modport sink   (input valid, input pixel_position, input channel,
                  input bit_value, input out_of_range, input run_last,
                  output ready);
endinterface

### src/lsb_stego_embed_sequencer.sv
`timescale 1ns / 1ps
// top level of the lsb stego embed sequencer
// Takes one message word per accept and issues one pixel write command word per
// cycle while the output is ready: seven for a character, seven more for the
// end-of-text code when the word ends the message. The next word is taken in the
// cycle the last command of the current one moves to the output register, so with
// the output always ready the commands of successive words follow without a gap.
// Configuration is written through a plain write port; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module lsb_stego_embed_sequencer #(
  parameter int POSITION_BITS = 24,
  parameter int KEY_MAX_BYTES = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lse_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lse_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  lse_in_if.sink                           in_if,
  lse_out_if.source                        out_if
);
  import lse_pkg::*;

  logic [OFFSET_W-1:0]  start_offset_q;
  logic [OFFSET_W-1:0]  pixel_count_q;
  logic [KEY_W-1:0]     key_bytes_q;
  logic [KEY_LEN_W-1:0] key_length_q;
  item_t                item;
  logic                 accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_offset_q <= '0;
      pixel_count_q  <= '0;
      key_bytes_q    <= '0;
      key_length_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_OFFSET: start_offset_q <= cfg_data_i[OFFSET_W-1:0];
        REG_PIXEL_COUNT:  pixel_count_q  <= cfg_data_i[OFFSET_W-1:0];
        REG_KEY_BYTES:    key_bytes_q    <= cfg_data_i[KEY_W-1:0];
        REG_KEY_LENGTH:   key_length_q   <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_if.valid & in_if.ready;

  lse_key_xor #(
    .KEY_MAX_BYTES(KEY_MAX_BYTES)
  ) u_key_xor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .char_code_i    (in_if.char_code),
    .char_present_i (in_if.char_present),
    .message_end_i  (in_if.message_end),
    .key_bytes_i    (key_bytes_q),
    .key_length_i   (key_length_q),
    .item_o         (item)
  );

  lse_bit_emitter #(
    .POSITION_BITS(POSITION_BITS)
  ) u_bit_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_if.valid),
    .in_ready_o     (in_if.ready),
    .item_i         (item),
    .start_offset_i (start_offset_q),
    .pixel_count_i  (pixel_count_q),
    .out_if         (out_if)
  );

endmodule

### src/lse_key_xor.sv
`timescale 1ns / 1ps
// key byte selection, xor and message start tracking at word accept
module lse_key_xor #(
  parameter int KEY_MAX_BYTES = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic [7:0]                      char_code_i,
  input  logic                            char_present_i,
  input  logic                            message_end_i,
  input  logic [lse_pkg::KEY_W-1:0]       key_bytes_i,
  input  logic [lse_pkg::KEY_LEN_W-1:0]   key_length_i,
  output lse_pkg::item_t                  item_o
);
  import lse_pkg::*;

  logic                 started_q, started_d;
  logic [KEY_IDX_W-1:0] key_idx_q, key_idx_d;
  logic [KEY_LEN_W-1:0] key_len;
  logic [KEY_IDX_W-1:0] k;
  logic [KEY_LEN_W-1:0] k_inc;
  logic [7:0]           key_byte;
  logic [7:0]           code;
  logic                 active;

  assign active  = char_present_i | message_end_i;
  assign key_len = (key_length_i > KEY_LEN_W'(KEY_MAX_BYTES)) ?
                   KEY_LEN_W'(KEY_MAX_BYTES) : key_length_i;

  always_comb begin
    k = key_idx_q;
    if (!started_q || ({1'b0, key_idx_q} >= key_len)) begin
      k = '0;
    end
    k_inc    = {1'b0, k} + KEY_LEN_W'(1);
    key_byte = key_bytes_i[8*k +: 8];
    code     = (key_len != '0) ? (char_code_i ^ key_byte) : char_code_i;
  end

  always_comb begin
    started_d = started_q;
    key_idx_d = key_idx_q;
    if (accept_i && active) begin
      started_d = ~message_end_i;
      if (!started_q) begin
        key_idx_d = '0;
      end
      if (char_present_i && (key_len != '0)) begin
        key_idx_d = (k_inc >= key_len) ? '0 : k_inc[KEY_IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      key_idx_q <= '0;
    end else begin
      started_q <= started_d;
      key_idx_q <= key_idx_d;
    end
  end

  assign item_o.code     = code[CHAR_BITS-1:0];
  assign item_o.has_char = char_present_i;
  assign item_o.has_end  = message_end_i;
  assign item_o.restart  = ~started_q;

endmodule

### src/lse_bit_emitter.sv
`timescale 1ns / 1ps
// bit sequencer, position stepping and registered write command output
module lse_bit_emitter #(
  parameter int POSITION_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lse_pkg::item_t                item_i,
  input  logic [lse_pkg::OFFSET_W-1:0]  start_offset_i,
  input  logic [lse_pkg::OFFSET_W-1:0]  pixel_count_i,
  lse_out_if.source                     out_if
);
  import lse_pkg::*;

  localparam int CMP_W = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;

  logic                     busy_q, busy_d;
  logic [SEQ_BITS-1:0]      seq_q, seq_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     restart_q, restart_d;
  logic [POSITION_BITS-1:0] pos_q;
  logic [2:0]               step_q;
  logic [1:0]               chan_q;
  logic                     ov_q;
  logic [OFFSET_W-1:0]      pix_q;
  logic [1:0]               ch_q;
  logic                     bit_q;
  logic                     oor_q;
  logic                     last_q;

  logic                     fire;
  logic                     last_bit;
  logic                     load;
  logic [POSITION_BITS-1:0] pos_cur;
  logic [2:0]               step_cur;
  logic [1:0]               chan_cur;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         pcnt_ext;

  assign fire       = busy_q & (~ov_q | out_if.ready);
  assign last_bit   = (cnt_q == CNT_W'(1));
  assign in_ready_o = ~busy_q | (fire & last_bit);
  assign load       = in_valid_i & in_ready_o & (item_i.has_char | item_i.has_end);

  // a restarting word takes its first position from the offset register
  assign pos_cur  = restart_q ? POSITION_BITS'(start_offset_i) : pos_q;
  assign step_cur = restart_q ? 3'd0 : step_q;
  assign chan_cur = restart_q ? 2'd0 : chan_q;
  assign pos_ext  = CMP_W'(pos_cur);
  assign pcnt_ext = CMP_W'(pixel_count_i);

  always_comb begin
    busy_d    = busy_q;
    seq_d     = seq_q;
    cnt_d     = cnt_q;
    restart_d = restart_q;
    if (fire) begin
      seq_d     = {seq_q[SEQ_BITS-2:0], 1'b0};
      cnt_d     = cnt_q - CNT_W'(1);
      restart_d = 1'b0;
      busy_d    = ~last_bit;
    end
    if (load) begin
      busy_d    = 1'b1;
      restart_d = item_i.restart;
      if (item_i.has_char) begin
        seq_d = {item_i.code, EOT_CODE};
        cnt_d = item_i.has_end ? CNT_W'(SEQ_BITS) : CNT_W'(CHAR_BITS);
      end else begin
        seq_d = {EOT_CODE, {CHAR_BITS{1'b0}}};
        cnt_d = CNT_W'(CHAR_BITS);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      cnt_q     <= '0;
      restart_q <= 1'b0;
      pos_q     <= '0;
      step_q    <= '0;
      chan_q    <= '0;
      ov_q      <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
      restart_q <= restart_d;
      if (fire) begin
        pos_q  <= pos_cur + POSITION_BITS'(step_size(step_cur));
        step_q <= (step_cur >= STEP_LAST) ? 3'd0 : step_cur + 3'd1;
        chan_q <= (chan_cur == 2'd2) ? 2'd0 : chan_cur + 2'd1;
        ov_q   <= 1'b1;
      end else if (out_if.ready) begin
        ov_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
    if (fire) begin
      pix_q  <= pos_ext[OFFSET_W-1:0];
      ch_q   <= chan_cur;
      bit_q  <= seq_q[SEQ_BITS-1];
      oor_q  <= (pos_ext >= pcnt_ext);
      last_q <= last_bit;
    end
  end

  assign out_if.valid          = ov_q;
  assign out_if.pixel_position = pix_q;
  assign out_if.channel        = ch_q;
  assign out_if.bit_value      = bit_q;
  assign out_if.out_of_range   = oor_q;
  assign out_if.run_last       = last_q;

endmodule
